// ===== src/tbeq_pkg.sv =====
// Shared constants, types and codes for the three-band equalizer.
package tbeq_pkg;

    localparam int SAMPLE_BITS    = 16;
    localparam int COEF_FRAC_BITS = 16;
    localparam int COEF_BITS      = COEF_FRAC_BITS + 1;
    localparam int GAIN_BITS      = 16;
    localparam int GAIN_FRAC_BITS = 12;

    localparam int POLE_BITS  = 32;
    localparam int POLE_FRAC  = POLE_BITS - SAMPLE_BITS;
    localparam int BAND_BITS  = POLE_BITS + 1;
    localparam int MUL_B_BITS = ((COEF_BITS > GAIN_BITS) ? COEF_BITS : GAIN_BITS) + 1;
    localparam int PROD_BITS  = BAND_BITS + MUL_B_BITS;
    localparam int ACC_BITS   = PROD_BITS + 2;
    localparam int OUT_SHIFT  = GAIN_FRAC_BITS + POLE_FRAC;

    localparam int NUM_POLES     = 4;
    localparam int POLE_IDX_BITS = $clog2(2 * NUM_POLES);
    localparam int LAST_LOW_POLE = NUM_POLES - 1;
    localparam int LAST_POLE     = 2 * NUM_POLES - 1;

    localparam int DLY_TAPS      = 3;
    localparam int DLY_PTR_BITS  = $clog2(DLY_TAPS);

    localparam int MEM_DEPTH     = 16;
    localparam int MEM_ADDR_BITS = $clog2(MEM_DEPTH);
    localparam int LOW_BASE      = 0;
    localparam int HIGH_BASE     = NUM_POLES;
    localparam int DLY_BASE      = 2 * NUM_POLES;

    localparam int CFG_DATA_BITS = 32;
    localparam int CFG_ADDR_BITS = 5;
    localparam int CFG_IDX_BITS  = 3;

    localparam logic [COEF_BITS-1:0] LOW_COEF_RST  = COEF_BITS'(7545);
    localparam logic [COEF_BITS-1:0] HIGH_COEF_RST = COEF_BITS'(42132);
    localparam logic [GAIN_BITS-1:0] LOW_GAIN_RST  = GAIN_BITS'(10240);
    localparam logic [GAIN_BITS-1:0] MID_GAIN_RST  = GAIN_BITS'(4096);
    localparam logic [GAIN_BITS-1:0] HIGH_GAIN_RST = GAIN_BITS'(4096);

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_LOW_COEF  = 3'd0,
        REG_HIGH_COEF = 3'd1,
        REG_LOW_GAIN  = 3'd2,
        REG_MID_GAIN  = 3'd3,
        REG_HIGH_GAIN = 3'd4
    } t_reg_idx;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIFF,
        S_MUL,
        S_UPD,
        S_BAND,
        S_GLOW,
        S_GMID,
        S_GHIGH,
        S_SUM
    } t_state;

    typedef struct packed {
        logic                          we;
        logic [MEM_ADDR_BITS-1:0]      waddr;
        logic signed [POLE_BITS-1:0]   wdata;
        logic [MEM_ADDR_BITS-1:0]      raddr;
    } t_mem_req;

endpackage

// ===== src/tbeq_in_if.sv =====
// Input sample channel.
interface tbeq_in_if
    import tbeq_pkg::*;
;
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_in;

    modport source (output valid, output sample_in, input ready);
    modport sink   (input valid, input sample_in, output ready);
endinterface

// ===== src/tbeq_out_if.sv =====
// Output sample channel.
interface tbeq_out_if
    import tbeq_pkg::*;
;
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_out;

    modport source (output valid, output sample_out, input ready);
    modport sink   (input valid, input sample_out, output ready);
endinterface

// ===== src/tbeq_state_mem.sv =====
// Filter state memory: poles and delay taps, registered read.
module tbeq_state_mem
    import tbeq_pkg::*;
(
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  t_mem_req                    i_req,
    output logic signed [POLE_BITS-1:0] o_rdata
);

    logic signed [POLE_BITS-1:0] r_mem [MEM_DEPTH];
    logic [MEM_DEPTH-1:0]        r_valid;
    logic signed [POLE_BITS-1:0] r_rdata;
    logic                        r_rvalid;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        r_rdata <= r_mem[i_req.raddr];
    end

    // Entries never written since reset read as zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rvalid <= 1'b0;
        end else begin
            if (i_req.we) begin
                r_valid[i_req.waddr] <= 1'b1;
            end
            r_rvalid <= r_valid[i_req.raddr];
        end
    end

    assign o_rdata = r_rvalid ? r_rdata : '0;

endmodule

// ===== src/three_band_equalizer_core.sv =====
// Three-band equalizer core: sequencer, shared multiplier and register file.
//
//  channel      dir   handshake          payload
//  i_sample_if  in    valid/ready        sample_in  (signed, SAMPLE_BITS)
//  o_sample_if  out   valid/ready        sample_out (signed, SAMPLE_BITS, saturated)
//  APB          cfg   psel/penable       5 registers at 4*i, pready tied high
//
// Each item is accepted in S_IDLE; each of the 8 poles then runs S_DIFF, S_MUL, S_UPD
// (pole read from the state memory, difference, multiply, update and write back on one
// shared multiplier); S_BAND to S_SUM do band split, three gain products, saturating sum.
// Reset clears the memory valid bits at once, so every pole and tap reads zero.
// A finished result waits in the output register while the next item is taken;
// if it is still waiting when that item finishes, the sequencer holds in its last step.
module three_band_equalizer_core
    import tbeq_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    tbeq_in_if.sink                  i_sample_if,
    tbeq_out_if.source               o_sample_if,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [CFG_ADDR_BITS-1:0] paddr,
    input  logic [CFG_DATA_BITS-1:0] pwdata,
    output logic [CFG_DATA_BITS-1:0] prdata,
    output logic                     pready
);

    function automatic logic signed [POLE_BITS-1:0] sat_pole(
        input logic signed [PROD_BITS:0] v
    );
        logic [PROD_BITS-POLE_BITS+1:0] hi;
        hi = v[PROD_BITS:POLE_BITS-1];
        if ((&hi) || !(|hi)) begin
            return v[POLE_BITS-1:0];
        end else if (v[PROD_BITS]) begin
            return {1'b1, {(POLE_BITS-1){1'b0}}};
        end else begin
            return {1'b0, {(POLE_BITS-1){1'b1}}};
        end
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] sat_out(
        input logic signed [ACC_BITS-1:0] v
    );
        logic [ACC_BITS-SAMPLE_BITS:0] hi;
        hi = v[ACC_BITS-1:SAMPLE_BITS-1];
        if ((&hi) || !(|hi)) begin
            return v[SAMPLE_BITS-1:0];
        end else if (v[ACC_BITS-1]) begin
            return {1'b1, {(SAMPLE_BITS-1){1'b0}}};
        end else begin
            return {1'b0, {(SAMPLE_BITS-1){1'b1}}};
        end
    endfunction

    // Configuration registers
    logic [COEF_BITS-1:0] r_low_coef, r_high_coef;
    logic [GAIN_BITS-1:0] r_low_gain, r_mid_gain, r_high_gain;
    logic                 cfg_wr;
    t_reg_idx             cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = t_reg_idx'(paddr[CFG_ADDR_BITS-1:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low_coef  <= LOW_COEF_RST;
            r_high_coef <= HIGH_COEF_RST;
            r_low_gain  <= LOW_GAIN_RST;
            r_mid_gain  <= MID_GAIN_RST;
            r_high_gain <= HIGH_GAIN_RST;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_LOW_COEF:  r_low_coef  <= pwdata[COEF_BITS-1:0];
                REG_HIGH_COEF: r_high_coef <= pwdata[COEF_BITS-1:0];
                REG_LOW_GAIN:  r_low_gain  <= pwdata[GAIN_BITS-1:0];
                REG_MID_GAIN:  r_mid_gain  <= pwdata[GAIN_BITS-1:0];
                REG_HIGH_GAIN: r_high_gain <= pwdata[GAIN_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_LOW_COEF:  prdata = CFG_DATA_BITS'(r_low_coef);
            REG_HIGH_COEF: prdata = CFG_DATA_BITS'(r_high_coef);
            REG_LOW_GAIN:  prdata = CFG_DATA_BITS'(r_low_gain);
            REG_MID_GAIN:  prdata = CFG_DATA_BITS'(r_mid_gain);
            REG_HIGH_GAIN: prdata = CFG_DATA_BITS'(r_high_gain);
            default:       prdata = '0;
        endcase
    end

    // Sequencer and datapath state
    t_state                        r_state, n_state;
    logic [POLE_IDX_BITS-1:0]      r_idx;
    logic [DLY_PTR_BITS-1:0]       r_dly_ptr;
    logic signed [POLE_BITS-1:0]   r_x, r_in, r_pole, r_low, r_hp;
    logic signed [BAND_BITS-1:0]   r_diff, r_h, r_m;
    logic signed [PROD_BITS-1:0]   r_prod;
    logic signed [ACC_BITS-1:0]    r_acc;
    logic signed [SAMPLE_BITS-1:0] r_out;
    logic                          r_out_valid;

    logic                          in_acc, out_free, last_pole, high_side;
    logic signed [POLE_BITS-1:0]   x_scaled, mem_rdata, new_pole;
    logic signed [PROD_BITS-1:0]   pole_step;
    logic signed [PROD_BITS:0]     pole_sum;
    logic signed [ACC_BITS-1:0]    acc_total, acc_shifted;
    logic signed [BAND_BITS-1:0]   mul_a;
    logic signed [MUL_B_BITS-1:0]  mul_b;
    logic signed [PROD_BITS-1:0]   mul_p;
    logic [COEF_BITS-1:0]          coef;
    logic [MEM_ADDR_BITS-1:0]      dly_addr;
    t_mem_req                      mem_req;

    assign in_acc    = i_sample_if.valid && i_sample_if.ready;
    assign out_free  = !r_out_valid || o_sample_if.ready;
    assign last_pole = (r_idx == POLE_IDX_BITS'(LAST_POLE));
    assign high_side = (r_idx >= POLE_IDX_BITS'(HIGH_BASE));
    assign coef      = high_side ? r_high_coef : r_low_coef;
    assign x_scaled  = POLE_BITS'(i_sample_if.sample_in) <<< POLE_FRAC;
    assign dly_addr  = MEM_ADDR_BITS'(DLY_BASE) + MEM_ADDR_BITS'(r_dly_ptr);

    assign pole_step = r_prod >>> COEF_FRAC_BITS;
    assign pole_sum  = (PROD_BITS + 1)'(r_pole) + (PROD_BITS + 1)'(pole_step);
    assign new_pole  = sat_pole(pole_sum);

    assign acc_total   = r_acc + ACC_BITS'(r_prod);
    assign acc_shifted = acc_total >>> OUT_SHIFT;

    // Shared multiplier
    always_comb begin
        unique case (r_state)
            S_GLOW: begin
                mul_a = BAND_BITS'(r_low);
                mul_b = $signed(MUL_B_BITS'(r_low_gain));
            end
            S_GMID: begin
                mul_a = r_m;
                mul_b = $signed(MUL_B_BITS'(r_mid_gain));
            end
            S_GHIGH: begin
                mul_a = r_h;
                mul_b = $signed(MUL_B_BITS'(r_high_gain));
            end
            default: begin
                mul_a = r_diff;
                mul_b = $signed(MUL_B_BITS'(coef));
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    tbeq_state_mem u_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mem_req),
        .o_rdata (mem_rdata)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (in_acc) n_state = S_DIFF;
            S_DIFF:  n_state = S_MUL;
            S_MUL:   n_state = S_UPD;
            S_UPD:   n_state = last_pole ? S_BAND : S_DIFF;
            S_BAND:  n_state = S_GLOW;
            S_GLOW:  n_state = S_GMID;
            S_GMID:  n_state = S_GHIGH;
            S_GHIGH: n_state = S_SUM;
            S_SUM:   if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // State outputs: handshake and memory access. Read the next pole one step ahead;
    // a pole is never read and written in the same cycle.
    always_comb begin
        i_sample_if.ready = 1'b0;
        mem_req.we        = 1'b0;
        mem_req.waddr     = MEM_ADDR_BITS'(r_idx);
        mem_req.wdata     = new_pole;
        mem_req.raddr     = MEM_ADDR_BITS'(r_idx);
        unique case (r_state)
            S_IDLE: begin
                i_sample_if.ready = 1'b1;
                mem_req.raddr     = MEM_ADDR_BITS'(LOW_BASE);
            end
            S_UPD: begin
                mem_req.we    = 1'b1;
                mem_req.raddr = last_pole ? dly_addr : MEM_ADDR_BITS'(r_idx) + 1'b1;
            end
            S_BAND: begin
                mem_req.we    = 1'b1;
                mem_req.waddr = dly_addr;
                mem_req.wdata = r_x;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idx       <= '0;
            r_dly_ptr   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_UPD) begin
                r_idx <= r_idx + 1'b1;
            end
            if (r_state == S_BAND) begin
                r_dly_ptr <= (r_dly_ptr == DLY_PTR_BITS'(DLY_TAPS - 1)) ?
                             '0 : r_dly_ptr + 1'b1;
            end
            if (r_state == S_SUM && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_sample_if.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_x  <= x_scaled;
                r_in <= x_scaled;
            end
            S_DIFF: begin
                r_pole <= mem_rdata;
                r_diff <= BAND_BITS'(r_in) - BAND_BITS'(mem_rdata);
            end
            S_MUL: begin
                r_prod <= mul_p;
            end
            S_UPD: begin
                // Feed the high cascade from the sample once the low one is done.
                r_in <= (r_idx == POLE_IDX_BITS'(LAST_LOW_POLE)) ? r_x : new_pole;
                if (r_idx == POLE_IDX_BITS'(LAST_LOW_POLE)) begin
                    r_low <= new_pole;
                end
                if (last_pole) begin
                    r_hp <= new_pole;
                end
            end
            S_BAND: begin
                r_h <= BAND_BITS'(mem_rdata) - BAND_BITS'(r_hp);
                r_m <= BAND_BITS'(r_hp) - BAND_BITS'(r_low);
            end
            S_GLOW: begin
                r_prod <= mul_p;
            end
            S_GMID: begin
                r_prod <= mul_p;
                r_acc  <= ACC_BITS'(r_prod);
            end
            S_GHIGH: begin
                r_prod <= mul_p;
                r_acc  <= acc_total;
            end
            S_SUM: begin
                if (out_free) begin
                    r_out <= sat_out(acc_shifted);
                end
            end
            default: ;
        endcase
    end

    assign o_sample_if.valid      = r_out_valid;
    assign o_sample_if.sample_out = r_out;

endmodule

// ===== src/tbeq_checker.sv =====
// Port-level checks for the equalizer core, bound into three_band_equalizer_core.
module tbeq_checker
    import tbeq_pkg::*;
(
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          i_in_ready,
    input logic                          i_out_valid,
    input logic                          i_out_ready,
    input logic signed [SAMPLE_BITS-1:0] i_out_sample
);

    logic       in_beat, out_beat;
    logic [1:0] r_pend;

    assign in_beat  = i_in_valid && i_in_ready;
    assign out_beat = i_out_valid && i_out_ready;

    // Track items taken in but not yet delivered.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else begin
            r_pend <= r_pend + {1'b0, in_beat} - {1'b0, out_beat};
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("output beat dropped before it was taken");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out_sample))
        else $error("output sample changed while stalled");

    a_in_spacing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_beat |=> !in_beat)
        else $error("input beats accepted in consecutive cycles");

    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pend == 2'd0) |-> !i_out_valid)
        else $error("output beat without an input beat behind it");

    a_pend_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pend == 2'd2) |-> !i_in_ready)
        else $error("input accepted with two items already in flight");

endmodule

bind three_band_equalizer_core tbeq_checker u_tbeq_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_sample_if.valid),
    .i_in_ready   (i_sample_if.ready),
    .i_out_valid  (o_sample_if.valid),
    .i_out_ready  (o_sample_if.ready),
    .i_out_sample (o_sample_if.sample_out)
);
